// ===== hw/rtl/multibyte_text_glyph_addresser_defines.svh =====
// Assertion macros for the multibyte text glyph addresser checker.
// Used by mtga_checker.sv; no other dependencies.
`ifndef MULTIBYTE_TEXT_GLYPH_ADDRESSER_DEFINES_SVH
`define MULTIBYTE_TEXT_GLYPH_ADDRESSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MTGA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtga: check failed");

// Next-cycle implication, disabled during reset.
`define MTGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtga: check failed");

`endif

// ===== hw/rtl/mtga_pkg.sv =====
// Shared types and constants for the multibyte text glyph addresser.
// No dependencies.
`timescale 1ns / 1ps

package mtga_pkg;

  localparam int ADDR_BITS_DEFAULT   = 20;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int HALF_FONT_BYTES     = 4096;

  localparam logic [1:0] MODE_ASCII = 2'd0;
  localparam logic [1:0] MODE_GB    = 2'd1;
  localparam logic [1:0] MODE_SJIS  = 2'd2;
  localparam logic [1:0] MODE_OFF   = 2'd3;

  localparam logic [1:0] STRIDE_CONTIG     = 2'd1;
  localparam logic [1:0] STRIDE_INTERLEAVE = 2'd2;

  localparam logic [2:0] REG_LANG_MODE = 3'd0;

  // Command record passed from front to back (address travels beside it).
  typedef struct packed {
    logic        font_select;
    logic        pair;
    logic [1:0]  row_stride;
    logic [15:0] pen_x;
    logic [15:0] row_y;
    logic [7:0]  color;
  } cmd_t;

endpackage

// ===== hw/rtl/mtga_front.sv =====
// Front end: accepts text bytes, tracks pen and lead byte, classifies and
// computes glyph addresses. Depends on mtga_pkg.
`timescale 1ns / 1ps

module mtga_front #(
  parameter int ADDR_BITS = mtga_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           lang_mode,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [55:0]          s_tdata,
  input  logic                 q_full,
  output logic                 push,
  output mtga_pkg::cmd_t       push_cmd,
  output logic [ADDR_BITS-1:0] push_addr
);

  localparam logic [ADDR_BITS-1:0] HalfFont = ADDR_BITS'(mtga_pkg::HALF_FONT_BYTES);

  logic [7:0]  lead_byte;
  logic [7:0]  lead_byte_next;
  logic [15:0] pen_x;
  logic [15:0] pen_x_next;

  logic [7:0]  code_byte;
  logic        first_of_string;
  logic [15:0] start_x;
  logic [15:0] row_y;
  logic [7:0]  color;
  logic        accept;
  logic [15:0] pen;
  logic        is_lead;
  logic        emit;

  logic signed [9:0]  lw;
  logic signed [9:0]  tw;
  logic signed [9:0]  k;
  logic signed [9:0]  t;
  logic signed [15:0] idx;
  logic [ADDR_BITS-1:0] idx_ext;
  logic [ADDR_BITS-1:0] pair_addr;
  logic [ADDR_BITS-1:0] single_addr;

  assign code_byte       = s_tdata[7:0];
  assign first_of_string = s_tdata[8];
  assign start_x         = s_tdata[24:9];
  assign row_y           = s_tdata[40:25];
  assign color           = s_tdata[48:41];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign lw = $signed({2'b00, lead_byte});
  assign tw = $signed({2'b00, code_byte});

  always_comb begin
    if (lang_mode == mtga_pkg::MODE_GB) begin
      k = lw - 10'sd161;
      t = tw - 10'sd161;
    end else begin
      if (lead_byte >= 8'h81 && lead_byte <= 8'h9f) begin
        k = (lw <<< 1) - 10'sd258;
      end else begin
        k = (lw <<< 1) - 10'sd386;
      end
      if (code_byte >= 8'h40 && code_byte <= 8'h7e) begin
        t = tw - 10'sd64;
      end else if (code_byte >= 8'h80 && code_byte <= 8'h9e) begin
        t = tw - 10'sd65;
      end else begin
        t = tw - 10'sd159;
        k = k + 10'sd1;
      end
    end
  end

  assign idx         = {{6{k[9]}}, k} * 16'sd94 + {{6{t[9]}}, t};
  assign idx_ext     = {{(ADDR_BITS-16){idx[15]}}, idx};
  assign pair_addr   = HalfFont + (idx_ext << 5);
  assign single_addr = {{(ADDR_BITS-12){1'b0}}, code_byte, 4'b0000};

  always_comb begin
    if (lang_mode == mtga_pkg::MODE_GB) begin
      is_lead = code_byte >= 8'h81 && code_byte <= 8'hfe;
    end else begin
      is_lead = (code_byte >= 8'h81 && code_byte <= 8'h9f) ||
                (code_byte >= 8'he0 && code_byte <= 8'hfc);
    end
  end

  always_comb begin
    pen            = first_of_string ? start_x : pen_x;
    pen_x_next     = (code_byte != 8'd0) ? pen + 16'd8 : pen;
    lead_byte_next = lead_byte;
    emit           = 1'b0;
    push_cmd.font_select = 1'b1;
    push_cmd.pair        = 1'b0;
    push_cmd.row_stride  = mtga_pkg::STRIDE_CONTIG;
    push_cmd.pen_x       = pen;
    push_cmd.row_y       = row_y;
    push_cmd.color       = color;
    push_addr            = single_addr;
    if (code_byte != 8'd0) begin
      case (lang_mode)
        mtga_pkg::MODE_ASCII: begin
          emit = 1'b1;
          push_cmd.font_select = 1'b0;
        end
        mtga_pkg::MODE_GB, mtga_pkg::MODE_SJIS: begin
          if (lead_byte == 8'd0) begin
            if (is_lead) begin
              lead_byte_next = code_byte;
            end else begin
              emit = 1'b1;
            end
          end else begin
            lead_byte_next = 8'd0;
            emit           = 1'b1;
            push_cmd.pair  = 1'b1;
            push_addr      = pair_addr;
            if (lang_mode == mtga_pkg::MODE_GB) begin
              push_cmd.row_stride = mtga_pkg::STRIDE_INTERLEAVE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte <= 8'd0;
      pen_x     <= 16'd0;
    end else if (accept) begin
      lead_byte <= lead_byte_next;
      pen_x     <= pen_x_next;
    end
  end

endmodule

// ===== hw/rtl/mtga_queue.sv =====
// Short command queue between front and back end.
// Depends on mtga_pkg for the command record type.
`timescale 1ns / 1ps

module mtga_queue #(
  parameter int ADDR_BITS = mtga_pkg::ADDR_BITS_DEFAULT,
  parameter int DEPTH     = mtga_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mtga_pkg::cmd_t       push_cmd,
  input  logic [ADDR_BITS-1:0] push_addr,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output mtga_pkg::cmd_t       head_cmd,
  output logic [ADDR_BITS-1:0] head_addr
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mtga_pkg::cmd_t       cmd_mem  [DEPTH];
  logic [ADDR_BITS-1:0] addr_mem [DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [CW-1:0]        count;

  assign full      = count == CW'(DEPTH);
  assign empty     = count == '0;
  assign head_cmd  = cmd_mem[rd_ptr];
  assign head_addr = addr_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr]  <= push_cmd;
      addr_mem[wr_ptr] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/mtga_back.sv =====
// Back end: expands queued commands into one or two output transactions
// through a registered output stage. Depends on mtga_pkg.
`timescale 1ns / 1ps

module mtga_back #(
  parameter int ADDR_BITS = mtga_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  mtga_pkg::cmd_t       head_cmd,
  input  logic [ADDR_BITS-1:0] head_addr,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [((ADDR_BITS+42+7)/8)*8-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  localparam int PayW = ADDR_BITS + 42;
  localparam int OutW = ((ADDR_BITS + 42 + 7) / 8) * 8;

  logic                 phase;
  logic                 load;
  logic                 first_half;
  logic [ADDR_BITS-1:0] inc;

  logic [ADDR_BITS-1:0] out_addr;
  logic [1:0]           out_stride;
  logic [15:0]          out_x;
  logic [15:0]          out_y;
  logic [7:0]           out_color;

  assign load       = !empty && (!m_tvalid || m_tready);
  assign first_half = head_cmd.pair && !phase;
  assign pop        = load && !first_half;
  assign inc        = (head_cmd.row_stride == mtga_pkg::STRIDE_INTERLEAVE) ?
                      ADDR_BITS'(1) : ADDR_BITS'(16);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        phase    <= first_half;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_addr   <= phase ? head_addr + inc : head_addr;
      out_stride <= head_cmd.row_stride;
      out_x      <= first_half ? head_cmd.pen_x - 16'd8 : head_cmd.pen_x;
      out_y      <= head_cmd.row_y;
      out_color  <= head_cmd.color;
      m_tuser    <= head_cmd.font_select;
      m_tlast    <= !first_half;
    end
  end

  assign m_tdata = {{(OutW-PayW){1'b0}}, out_color, out_y, out_x, out_stride, out_addr};

endmodule

// ===== hw/rtl/multibyte_text_glyph_addresser.sv =====
// Multibyte text glyph addresser: text bytes in, glyph draw commands out.
// Uses mtga_pkg, mtga_front, mtga_queue and mtga_back.
//
// Usage:
//   Input stream (s_*): one text byte per transaction with pen and color
//   info. Output stream (m_*): glyph draw commands; tlast marks the final
//   command of a byte, tuser is the font select. APB port: register
//   lang_mode at address 0 (0 ascii, 1 gb2312, 2 shift-jis, 3 off); write
//   only while the block is idle.
//   Throughput: one byte per cycle while the queue is not full. A lead
//   byte gives no command and its trail gives two, so the single output
//   register keeps up with the input on average; the four-entry command
//   queue absorbs the burst. A command appears on m_* after the queue
//   write and then the output register load.
//   Reset clears pen x, the pending lead byte, the queue and lang_mode.
//   When the receiver stalls, the output register holds its command, the
//   queue fills and s_tready drops once the queue is full.
`timescale 1ns / 1ps

module multibyte_text_glyph_addresser #(
  parameter int ADDR_BITS   = mtga_pkg::ADDR_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = mtga_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // code_byte[7:0], first_of_string[8], start_x[24:9], row_y[40:25], color[48:41]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // glyph_address, row_stride, draw_x, draw_y, draw_color (from bit 0 up)
  output logic [((ADDR_BITS+42+7)/8)*8-1:0] m_tdata,
  // font_select
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]           lang_mode;
  logic                 q_full;
  logic                 q_empty;
  logic                 push;
  logic                 pop;
  mtga_pkg::cmd_t       push_cmd;
  mtga_pkg::cmd_t       head_cmd;
  logic [ADDR_BITS-1:0] push_addr;
  logic [ADDR_BITS-1:0] head_addr;
  logic                 mode_sel;

  assign pready   = 1'b1;
  assign mode_sel = {paddr[2], 2'b00} == mtga_pkg::REG_LANG_MODE;
  assign prdata   = mode_sel ? {30'd0, lang_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lang_mode <= mtga_pkg::MODE_ASCII;
    end else if (psel && penable && pwrite && pready && mode_sel) begin
      lang_mode <= pwdata[1:0];
    end
  end

  mtga_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .lang_mode (lang_mode),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr)
  );

  mtga_queue #(.ADDR_BITS(ADDR_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_cmd  (head_cmd),
    .head_addr (head_addr)
  );

  mtga_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head_cmd  (head_cmd),
    .head_addr (head_addr),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== hw/rtl/mtga_checker.sv =====
// Port-level checker for the multibyte text glyph addresser, bound to the
// top level. Depends on multibyte_text_glyph_addresser_defines.svh.
`timescale 1ns / 1ps
`include "multibyte_text_glyph_addresser_defines.svh"

module mtga_checker #(
  parameter int ADDR_BITS = mtga_pkg::ADDR_BITS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [((ADDR_BITS+42+7)/8)*8-1:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  localparam int XLo = ADDR_BITS + 2;

  logic [15:0] draw_x;

  assign draw_x = m_tdata[XLo +: 16];

  // stalled transaction holds
  `MTGA_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // left half is followed at once by the right half
  `MTGA_ASSERT_NEXT(a_pair_follow, clk, rst, m_tvalid && m_tready && !m_tlast,
                    m_tvalid && m_tlast)

  // right half sits 8 pixels right of the left half
  `MTGA_ASSERT_NEXT(a_pair_x, clk, rst, m_tvalid && m_tready && !m_tlast,
                    draw_x == $past(draw_x) + 16'd8)

  // left halves of glyph pairs always come from the language font
  `MTGA_ASSERT_SAME(a_pair_font, clk, rst, m_tvalid && !m_tlast, m_tuser)

endmodule

bind multibyte_text_glyph_addresser mtga_checker #(.ADDR_BITS(ADDR_BITS)) u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
